### src/lvsa_pkg.sv
`timescale 1ns / 1ps

package lvsa_pkg;

	localparam int ENTRY_W = 48;
	localparam int SUM_W = ENTRY_W + 1;
	localparam int PROD_W = 64;
	localparam int PP_W = 96;
	localparam int MAX_COMPONENTS = 3;
	localparam int COMP_IDX_W = 2;

	localparam logic [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
	localparam logic [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

	// Configuration register map (byte addresses) and reset value.
	localparam logic [1:0] REG_COMPONENTS = 2'd0;
	localparam logic [1:0] COMPONENTS_RESET = 2'd1;

	// Multiplier operand selection.
	localparam logic [1:0] MUL_NONE = 2'd0;
	localparam logic [1:0] MUL_JW = 2'd1;
	localparam logic [1:0] MUL_COMP = 2'd2;
	localparam logic [1:0] MUL_PP = 2'd3;

	// What the datapath does with the registered product.
	localparam logic [2:0] ACC_NONE = 3'd0;
	localparam logic [2:0] ACC_JW = 3'd1;
	localparam logic [2:0] ACC_TERM = 3'd2;
	localparam logic [2:0] ACC_PP0 = 3'd3;
	localparam logic [2:0] ACC_PP32 = 3'd4;
	localparam logic [2:0] ACC_PP64 = 3'd5;

	typedef struct packed {
		logic op;
		logic [16:0] dof_index;
		logic signed [31:0] element_area;
		logic signed [31:0] jacobian_det;
		logic signed [31:0] quad_weight;
		logic [MAX_COMPONENTS-1:0][31:0] shape;
		logic [MAX_COMPONENTS-1:0][31:0] source;
	} lvsa_item_t;

	typedef struct packed {
		logic latch;
		logic mem_rd;
		logic [1:0] mul_sel;
		logic [COMP_IDX_W-1:0] mul_idx;
		logic [2:0] acc_op;
		logic [COMP_IDX_W-1:0] term_idx;
		logic s_clr;
		logic mag;
		logic fin;
		logic wr_sum;
		logic rd_done;
		logic clr_wr;
	} lvsa_cmd_t;

	typedef struct packed {
		logic is_read;
		logic skip;
		logic clr_last;
		logic out_free;
	} lvsa_stat_t;

	function automatic logic [31:0] mag32(input logic [31:0] x);
		mag32 = x[31] ? (32'd0 - x) : x;
	endfunction

endpackage

### src/lvsa_ctrl.sv
`timescale 1ns / 1ps

module lvsa_ctrl (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input lvsa_pkg::lvsa_stat_t stat,
	output lvsa_pkg::lvsa_cmd_t cmd
);

	localparam logic [3:0] ST_CLR = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_DEC = 4'd2;
	localparam logic [3:0] ST_RDW = 4'd3;
	localparam logic [3:0] ST_JW = 4'd4;
	localparam logic [3:0] ST_MUL = 4'd5;
	localparam logic [3:0] ST_SUM = 4'd6;
	localparam logic [3:0] ST_MAG = 4'd7;
	localparam logic [3:0] ST_PP = 4'd8;
	localparam logic [3:0] ST_PEND = 4'd9;
	localparam logic [3:0] ST_FIN = 4'd10;
	localparam logic [3:0] ST_ADD = 4'd11;

	localparam logic [1:0] LAST_COMP = 2'(lvsa_pkg::MAX_COMPONENTS - 1);
	localparam logic [1:0] LAST_PP = 2'd3;

	logic [3:0] state_q, state_d;
	logic [1:0] k_q, k_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		k_d = k_q;
		cmd = '0;
		cmd.mul_sel = lvsa_pkg::MUL_NONE;
		cmd.acc_op = lvsa_pkg::ACC_NONE;
		case (state_q)
			ST_CLR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.latch = item_valid;
				if (item_valid) begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				cmd.mem_rd = 1'b1;
				if (stat.is_read) begin
					state_d = ST_RDW;
				end else if (stat.skip) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_JW;
				end
			end
			ST_RDW: begin
				if (stat.out_free) begin
					cmd.rd_done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_JW: begin
				cmd.mul_sel = lvsa_pkg::MUL_JW;
				cmd.s_clr = 1'b1;
				k_d = 2'd0;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				// The product of the previous step is consumed while the next one is formed.
				cmd.mul_sel = lvsa_pkg::MUL_COMP;
				cmd.mul_idx = k_q;
				if (k_q == 2'd0) begin
					cmd.acc_op = lvsa_pkg::ACC_JW;
				end else begin
					cmd.acc_op = lvsa_pkg::ACC_TERM;
					cmd.term_idx = k_q - 2'd1;
				end
				if (k_q == LAST_COMP) begin
					k_d = 2'd0;
					state_d = ST_SUM;
				end else begin
					k_d = k_q + 2'd1;
				end
			end
			ST_SUM: begin
				cmd.acc_op = lvsa_pkg::ACC_TERM;
				cmd.term_idx = LAST_COMP;
				state_d = ST_MAG;
			end
			ST_MAG: begin
				cmd.mag = 1'b1;
				k_d = 2'd0;
				state_d = ST_PP;
			end
			ST_PP: begin
				cmd.mul_sel = lvsa_pkg::MUL_PP;
				cmd.mul_idx = k_q;
				case (k_q)
					2'd0: cmd.acc_op = lvsa_pkg::ACC_NONE;
					2'd1: cmd.acc_op = lvsa_pkg::ACC_PP0;
					default: cmd.acc_op = lvsa_pkg::ACC_PP32;
				endcase
				if (k_q == LAST_PP) begin
					k_d = 2'd0;
					state_d = ST_PEND;
				end else begin
					k_d = k_q + 2'd1;
				end
			end
			ST_PEND: begin
				cmd.acc_op = lvsa_pkg::ACC_PP64;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.wr_sum = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			k_q <= 2'd0;
		end else begin
			state_q <= state_d;
			k_q <= k_d;
		end
	end

endmodule

### src/lvsa_dp.sv
`timescale 1ns / 1ps

module lvsa_dp #(
	parameter int NDOF = 65536
) (
	input logic clk,
	input logic arst_n,
	input lvsa_pkg::lvsa_item_t item,
	input logic [1:0] components,
	input lvsa_pkg::lvsa_cmd_t cmd,
	output lvsa_pkg::lvsa_stat_t stat,
	input logic result_stall,
	output logic result_valid,
	output logic signed [lvsa_pkg::ENTRY_W-1:0] entry_value,
	output logic saturated
);

	localparam int AW = (NDOF > 1) ? $clog2(NDOF) : 1;
	localparam int EW = lvsa_pkg::ENTRY_W;
	localparam int SW = lvsa_pkg::SUM_W;
	localparam int NC = lvsa_pkg::MAX_COMPONENTS;

	// Item registers.
	logic op_q, valid_q, area_pos_q, wt_pos_q;
	logic [AW-1:0] slot_q;
	logic [31:0] jac_q, wt_q;
	logic [NC-1:0][31:0] shape_q, source_q;

	// Arithmetic registers.
	logic [lvsa_pkg::PROD_W-1:0] prod_q;
	logic mul_neg_q;
	logic [EW-1:0] jw_mag_q, s_mag_q;
	logic jw_neg_q, s_neg_q;
	logic [SW-1:0] s_q;
	logic [lvsa_pkg::PP_W-1:0] pp_q;
	logic [lvsa_pkg::PROD_W:0] mid_q;
	logic [EW-1:0] c_q;
	logic csat_q;

	// Vector store: bit EW is the saturation mark.
	logic [EW:0] vec_mem [NDOF];
	logic [EW:0] rdata_q;
	logic [AW-1:0] clr_cnt_q;

	logic result_valid_q, sat_out_q;
	logic [EW-1:0] entry_out_q;

	logic [31:0] idx_ext;
	logic idx_ok;
	logic [AW-1:0] slot_in;

	assign idx_ext = {15'd0, item.dof_index};
	assign idx_ok = (idx_ext != 32'd0) && (idx_ext <= 32'(NDOF));
	assign slot_in = AW'(idx_ext - 32'd1);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= item.op;
			valid_q <= idx_ok;
			slot_q <= slot_in;
			area_pos_q <= !item.element_area[31] && (item.element_area != 32'sd0);
			wt_pos_q <= !item.quad_weight[31] && (item.quad_weight != 32'sd0);
			jac_q <= item.jacobian_det;
			wt_q <= item.quad_weight;
			shape_q <= item.shape;
			source_q <= item.source;
		end
	end

	// Shared 32 x 32 unsigned multiplier working on magnitudes.
	logic [31:0] opa, opb;
	logic opneg;

	always_comb begin
		opa = 32'd0;
		opb = 32'd0;
		opneg = 1'b0;
		case (cmd.mul_sel)
			lvsa_pkg::MUL_JW: begin
				opa = lvsa_pkg::mag32(jac_q);
				opb = lvsa_pkg::mag32(wt_q);
				opneg = jac_q[31] ^ wt_q[31];
			end
			lvsa_pkg::MUL_COMP: begin
				opa = lvsa_pkg::mag32(shape_q[cmd.mul_idx]);
				opb = lvsa_pkg::mag32(source_q[cmd.mul_idx]);
				opneg = shape_q[cmd.mul_idx][31] ^ source_q[cmd.mul_idx][31];
			end
			lvsa_pkg::MUL_PP: begin
				opa = cmd.mul_idx[1] ? {16'd0, jw_mag_q[47:32]} : jw_mag_q[31:0];
				opb = cmd.mul_idx[0] ? {16'd0, s_mag_q[47:32]} : s_mag_q[31:0];
			end
			default: begin
				opa = 32'd0;
				opb = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= {32'd0, opa} * {32'd0, opb};
		mul_neg_q <= opneg;
	end

	// Dropping the low 16 bits of a magnitude truncates toward zero.
	logic [EW-1:0] term_mag;
	logic [SW-1:0] term_s;
	logic term_use;

	assign term_mag = prod_q[63:16];
	assign term_s = mul_neg_q ? (SW'(0) - {1'b0, term_mag}) : {1'b0, term_mag};
	assign term_use = (cmd.term_idx < components);

	always_ff @(posedge clk) begin
		if (cmd.s_clr) begin
			s_q <= '0;
		end
		case (cmd.acc_op)
			lvsa_pkg::ACC_JW: begin
				jw_mag_q <= prod_q[63:16];
				jw_neg_q <= mul_neg_q;
			end
			lvsa_pkg::ACC_TERM: begin
				if (term_use) begin
					s_q <= s_q + term_s;
				end
			end
			lvsa_pkg::ACC_PP0: begin
				pp_q <= {32'd0, prod_q};
				mid_q <= '0;
			end
			lvsa_pkg::ACC_PP32: begin
				pp_q <= pp_q + {prod_q, 32'd0};
				mid_q <= mid_q + {1'b0, prod_q};
			end
			lvsa_pkg::ACC_PP64: pp_q <= pp_q + {prod_q[31:0], 64'd0};
			default: ;
		endcase
		if (cmd.mag) begin
			s_mag_q <= s_q[SW-1] ? EW'(SW'(0) - s_q) : s_q[EW-1:0];
			s_neg_q <= s_q[SW-1];
		end
	end

	// Scale the full product back to Q.16 and clamp to the entry range.
	// A sum of the two middle partial products that reaches bit 31 counts as
	// overflow, even where the scaled result just reaches the most negative entry.
	logic c_neg, c_over;
	logic [79:0] q_full, q_limit;
	logic [EW-1:0] q_clamp;

	assign c_neg = jw_neg_q ^ s_neg_q;
	assign q_full = pp_q[95:16];
	assign q_limit = c_neg ? {32'd0, lvsa_pkg::ENTRY_MIN} : {32'd0, lvsa_pkg::ENTRY_MAX};
	assign c_over = (q_full > q_limit) || (mid_q[lvsa_pkg::PROD_W:31] != '0);
	assign q_clamp = c_over ? q_limit[EW-1:0] : q_full[EW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			c_q <= c_neg ? (EW'(0) - q_clamp) : q_clamp;
			csat_q <= c_over;
		end
	end

	logic [SW-1:0] sum;
	logic sum_ovf;
	logic [EW-1:0] sum_clamp;

	assign sum = {rdata_q[EW-1], rdata_q[EW-1:0]} + {c_q[EW-1], c_q};
	assign sum_ovf = sum[SW-1] ^ sum[EW-1];
	assign sum_clamp = sum_ovf ? (sum[SW-1] ? lvsa_pkg::ENTRY_MIN : lvsa_pkg::ENTRY_MAX)
		: sum[EW-1:0];

	// One write port, one registered read port.
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW:0] wr_data;

	always_comb begin
		wr_en = 1'b0;
		wr_addr = slot_q;
		wr_data = '0;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
			wr_addr = clr_cnt_q;
		end else if (cmd.wr_sum) begin
			wr_en = 1'b1;
			wr_data = {rdata_q[EW] | csat_q | sum_ovf, sum_clamp};
		end else if (cmd.rd_done && valid_q) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vec_mem[wr_addr] <= wr_data;
		end
		if (cmd.mem_rd) begin
			rdata_q <= vec_mem[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// Result register: the next item may start while a result waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.rd_done) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_done) begin
			entry_out_q <= valid_q ? rdata_q[EW-1:0] : '0;
			sat_out_q <= valid_q & rdata_q[EW];
		end
	end

	assign result_valid = result_valid_q;
	assign entry_value = entry_out_q;
	assign saturated = sat_out_q;

	assign stat.is_read = op_q;
	assign stat.skip = !valid_q || !area_pos_q || !wt_pos_q;
	assign stat.clr_last = (clr_cnt_q == AW'(NDOF - 1));
	assign stat.out_free = !result_valid_q || !result_stall;

endmodule

### src/load_vector_scatter_accumulate.sv
`timescale 1ns / 1ps

// Load vector scatter-accumulate engine for finite-element right-hand-side assembly.
// Items enter on item_valid / item_stall; an item is taken when item_valid is high
// and item_stall is low. An accumulate item (op 0) adds jacdet*weight*sum(shape*source)
// to entry dof_index with saturation and produces no result; it is skipped when the
// area or weight is not positive or the index is out of range. A read item (op 1)
// returns the entry and its saturation mark on result_valid / result_stall and clears it.
// The block handles one item at a time through a single shared 32 x 32 multiplier:
// an accumulate item occupies it for one Jacobian product, three component products,
// four partial products of the final scaling, plus read, clamp and write-back of the
// entry; a read registers its result once the output register is free.
// A skipped accumulate item returns to idle straight after decode.
// After reset the vector store is cleared one entry per cycle, all NDOF entries, during
// which item_stall stays high; configuration writes are taken at all times.
// A stalled result holds in the output register; the block keeps accepting items and
// only waits when a further read result needs that register.
// components_in_use lives at byte address 0 and resets to 1.
module load_vector_scatter_accumulate #(
	parameter int NDOF = 65536
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic item_valid,
	output logic item_stall,
	input logic op,
	input logic [16:0] dof_index,
	input logic signed [31:0] element_area,
	input logic signed [31:0] jacobian_det,
	input logic signed [31:0] quad_weight,
	input logic signed [31:0] shape_0,
	input logic signed [31:0] shape_1,
	input logic signed [31:0] shape_2,
	input logic signed [31:0] source_0,
	input logic signed [31:0] source_1,
	input logic signed [31:0] source_2,
	output logic result_valid,
	input logic result_stall,
	output logic signed [47:0] entry_value,
	output logic saturated
);

	logic [1:0] components_q;
	lvsa_pkg::lvsa_item_t item;
	lvsa_pkg::lvsa_cmd_t cmd;
	lvsa_pkg::lvsa_stat_t stat;

	assign pready = 1'b1;
	assign prdata = (paddr == lvsa_pkg::REG_COMPONENTS) ? {30'd0, components_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			components_q <= lvsa_pkg::COMPONENTS_RESET;
		end else if (psel && penable && pwrite && pready
			&& (paddr == lvsa_pkg::REG_COMPONENTS)) begin
			components_q <= pwdata[1:0];
		end
	end

	assign item.op = op;
	assign item.dof_index = dof_index;
	assign item.element_area = element_area;
	assign item.jacobian_det = jacobian_det;
	assign item.quad_weight = quad_weight;
	assign item.shape[0] = shape_0;
	assign item.shape[1] = shape_1;
	assign item.shape[2] = shape_2;
	assign item.source[0] = source_0;
	assign item.source[1] = source_1;
	assign item.source[2] = source_2;

	lvsa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.stat(stat),
		.cmd(cmd)
	);

	lvsa_dp #(
		.NDOF(NDOF)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.components(components_q),
		.cmd(cmd),
		.stat(stat),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.entry_value(entry_value),
		.saturated(saturated)
	);

endmodule

### src/lvsa_chk.sv
`timescale 1ns / 1ps

module lvsa_chk (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_stall,
	input logic op,
	input logic [16:0] dof_index,
	input logic result_valid,
	input logic result_stall,
	input logic signed [47:0] entry_value,
	input logic saturated
);

	// A waiting result is neither dropped nor altered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(entry_value) && $stable(saturated))
		else $error("result changed while stalled");

	// The store is being cleared right after reset, so no item is taken.
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> item_stall)
		else $error("item accepted during clearing pass");

	// Items are handled one at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second item accepted back to back");

	// A read of index zero, accepted while no result is waiting, returns an empty entry.
	a_zero_index_read: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && op && (dof_index == 17'd0) && !result_valid
		|=> ##2 (result_valid && (entry_value == 48'sd0) && !saturated))
		else $error("read of index zero returned a nonzero entry");

endmodule

bind load_vector_scatter_accumulate lvsa_chk u_lvsa_chk (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_stall(item_stall),
	.op(op),
	.dof_index(dof_index),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.entry_value(entry_value),
	.saturated(saturated)
);

### tb/sv/tb_load_vector_scatter_accumulate.sv
`timescale 1ns / 1ps

module tb_load_vector_scatter_accumulate;

	localparam int NDOF = 65536;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam longint VALUE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint VALUE_MIN = -VALUE_MAX - 1;
	localparam logic OP_ACCUMULATE = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct {
		logic signed [47:0] value;
		logic sat;
	} entry_read_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	lvsa_pkg::lvsa_item_t offer = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [47:0] entry_value;
	logic saturated;

	// Own copy of the vector store, its saturation marks and the component count.
	bit signed [47:0] rhs_entry [1:NDOF];
	bit rhs_mark [1:NDOF];
	int terms_in_use = 1;
	entry_read_t reads_due [$];
	lvsa_pkg::lvsa_item_t load_items [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_armed = 1'b0;
	int hold_count = 0;
	logic hold_active;
	int mismatch_count = 0;

	int phase_terms [4] = '{3, 0, 2, 1};
	int phase_items [4] = '{500, 100, 650, 700};
	int phase_send_idle [4] = '{23, 23, 67, 0};
	int phase_recv_idle [4] = '{67, 67, 23, 0};

	load_vector_scatter_accumulate i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(offer.op),
		.dof_index(offer.dof_index),
		.element_area(offer.element_area),
		.jacobian_det(offer.jacobian_det),
		.quad_weight(offer.quad_weight),
		.shape_0(offer.shape[0]),
		.shape_1(offer.shape[1]),
		.shape_2(offer.shape[2]),
		.source_0(offer.source[0]),
		.source_1(offer.source[1]),
		.source_2(offer.source[2]),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.entry_value(entry_value),
		.saturated(saturated)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic signed [63:0] got,
			input logic signed [63:0] want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic longint trunc_q16_product(input longint a, input longint b);
		return (a * b) / 65536;
	endfunction

	// Final scaling of jw by the dot product. A sum of the two middle partial products that reaches
	// bit 31 counts as overflow even when the truncated result would just fit.
	function automatic longint scale_clamped(input longint a, input longint b,
			output bit clamped);
		bit neg;
		logic [63:0] ma, mb, mid, q, limit;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? 64'(-a) : 64'(a);
		mb = (b < 0) ? 64'(-b) : 64'(b);
		limit = neg ? (64'd1 << 47) : ((64'd1 << 47) - 64'd1);
		clamped = 1'b0;
		if (ma[63:32] != 0 && mb[63:32] != 0) begin
			q = limit + 64'd1;
		end else begin
			mid = 64'(ma[63:32]) * 64'(mb[31:0]) + 64'(ma[31:0]) * 64'(mb[63:32]);
			if (mid >= (64'd1 << 31))
				q = limit + 64'd1;
			else
				q = (mid << 16) + ((64'(ma[31:0]) * 64'(mb[31:0])) >> 16);
		end
		if (q > limit) begin
			clamped = 1'b1;
			q = limit;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	task automatic assemble_contribution(input lvsa_pkg::lvsa_item_t it);
		int unsigned slot;
		bit in_range;
		bit clamped;
		longint jw, dot, sum;
		entry_read_t due;
		slot = it.dof_index;
		in_range = slot >= 1 && slot <= NDOF;
		if (it.op == OP_READ) begin
			due.value = in_range ? rhs_entry[slot] : '0;
			due.sat = in_range ? rhs_mark[slot] : 1'b0;
			reads_due.push_back(due);
			if (in_range) begin
				rhs_entry[slot] = '0;
				rhs_mark[slot] = 1'b0;
			end
		end else if (in_range && $signed(it.element_area) > 0
				&& $signed(it.quad_weight) > 0) begin
			jw = trunc_q16_product($signed(it.jacobian_det), $signed(it.quad_weight));
			dot = 0;
			for (int i = 0; i < terms_in_use; i++)
				dot += trunc_q16_product($signed(it.shape[i]), $signed(it.source[i]));
			sum = rhs_entry[slot] + scale_clamped(jw, dot, clamped);
			if (sum > VALUE_MAX) begin
				sum = VALUE_MAX;
				clamped = 1'b1;
			end else if (sum < VALUE_MIN) begin
				sum = VALUE_MIN;
				clamped = 1'b1;
			end
			rhs_entry[slot] = sum[47:0];
			if (clamped)
				rhs_mark[slot] = 1'b1;
		end
	endtask

	function automatic lvsa_pkg::lvsa_item_t make_read(input logic [16:0] dof);
		lvsa_pkg::lvsa_item_t it;
		it = '0;
		it.op = OP_READ;
		it.dof_index = dof;
		return it;
	endfunction

	function automatic lvsa_pkg::lvsa_item_t make_acc(input logic [16:0] dof,
			input logic [31:0] area, jac, wt, sh0, sr0, sh1, sr1, sh2, sr2);
		lvsa_pkg::lvsa_item_t it;
		it.op = OP_ACCUMULATE;
		it.dof_index = dof;
		it.element_area = area;
		it.jacobian_det = jac;
		it.quad_weight = wt;
		it.shape[0] = sh0;
		it.shape[1] = sh1;
		it.shape[2] = sh2;
		it.source[0] = sr0;
		it.source[1] = sr1;
		it.source[2] = sr2;
		return it;
	endfunction

	function automatic logic [31:0] random_q16();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom_range(0, 8 << 16);
			4, 5: v = $urandom();
			6: v = 32'h7FFF_FFFF;
			7: v = 32'h8000_0000;
			8: v = 32'h0;
			default: v = $urandom_range(0, 3);
		endcase
		if ($urandom_range(0, 1) == 1)
			v = -v;
		return v;
	endfunction

	// Area and weight: mostly positive, so that most accumulates take effect.
	function automatic logic [31:0] random_gate();
		case ($urandom_range(0, 19))
			0: return 32'h0;
			1: return 32'h8000_0000;
			2: return 32'h8000_0000 | $urandom();
			3: return 32'h7FFF_FFFF;
			4, 5: return $urandom_range(1, 32'h7FFF_FFFF);
			default: return $urandom_range(1, 4 << 16);
		endcase
	endfunction

	// A small working set keeps reads landing on entries that have been built up.
	function automatic logic [16:0] random_dof();
		case ($urandom_range(0, 19))
			0: return 17'($urandom_range(0, 17'h1FFFF));
			1: return 17'($urandom_range(1, NDOF));
			2, 3: return 17'(NDOF - $urandom_range(0, 3));
			default: return 17'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic lvsa_pkg::lvsa_item_t random_item();
		lvsa_pkg::lvsa_item_t it;
		it.op = ($urandom_range(0, 99) < 30) ? OP_READ : OP_ACCUMULATE;
		it.dof_index = random_dof();
		it.element_area = random_gate();
		it.jacobian_det = random_q16();
		it.quad_weight = random_gate();
		for (int i = 0; i < lvsa_pkg::MAX_COMPONENTS; i++) begin
			it.shape[i] = random_q16();
			it.source[i] = random_q16();
		end
		return it;
	endfunction

	task automatic write_components(input logic [1:0] count);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= lvsa_pkg::REG_COMPONENTS;
		pwdata <= {30'($urandom()), count};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		terms_in_use = count;
		// Read the register back in a transfer that follows directly.
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[1:0] !== count)
			report_mismatch("components_in_use readback", prdata[1:0], count);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (load_items.size() != 0 || item_valid || reads_due.size() != 0);
		// Accumulates give no result, so the block may still be busy with one.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				assemble_contribution(offer);
			if (!item_valid || !item_stall) begin
				if (load_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					item_valid <= 1'b1;
					offer <= load_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	assign hold_active = hold_armed && hold_count < HOLD_CYCLES;

	always @(posedge clk) begin
		if (hold_active)
			hold_count <= hold_count + 1;
	end

	always @(posedge clk) begin
		entry_read_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (reads_due.size() == 0) begin
				report_mismatch("result with no read waiting", entry_value, 0);
			end else begin
				want = reads_due.pop_front();
				if (entry_value !== want.value)
					report_mismatch("entry_value", entry_value, want.value);
				if (saturated !== want.sat)
					report_mismatch("saturated", saturated, want.sat);
			end
		end
		result_stall <= hold_active || ($urandom_range(0, 99) < recv_idle_pct);
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset count of one, only the first component pair counts.
		load_items.push_back(make_read(17'd1));
		load_items.push_back(make_acc(17'd5, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000,
			32'h0003_0000, 32'h0001_0000, 32'h0005_0000, 32'h0002_0000,
			32'h0007_0000, 32'hFFFF_0000));
		load_items.push_back(make_read(17'd5));
		wait_until_drained();
		write_components(2'd3);

		// All fields at their maximum: positive overflow on the smallest area.
		load_items.push_back(make_acc(17'd1, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF));
		load_items.push_back(make_read(17'd1));
		load_items.push_back(make_read(17'd1));
		load_items.push_back(make_acc(17'h10000, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000));
		load_items.push_back(make_read(17'h10000));
		// Indices outside the store.
		load_items.push_back(make_acc(17'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0));
		load_items.push_back(make_read(17'd0));
		load_items.push_back(make_acc(17'h1FFFF, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0));
		load_items.push_back(make_read(17'h1FFFF));
		load_items.push_back(make_read(17'h10001));
		// Non-positive area or weight leaves the entry alone.
		load_items.push_back(make_acc(17'd7, 32'h0, 32'h0001_0000, 32'h0001_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0));
		load_items.push_back(make_acc(17'd7, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0));
		load_items.push_back(make_acc(17'd7, 32'h0001_0000, 32'h0001_0000, 32'h0,
			32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0));
		load_items.push_back(make_acc(17'd7, 32'h0001_0000, 32'h0001_0000, 32'h8000_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0));
		load_items.push_back(make_read(17'd7));
		// Back-to-back accumulates on one entry with truncation toward zero.
		load_items.push_back(make_acc(17'd9, 32'h7FFF_FFFF, 32'hFFFD_0001, 32'h0000_8001,
			32'hFFFE_8000, 32'h0003_4567, 32'h0001_2345, 32'hFFFF_FFFF,
			32'h8000_0001, 32'h0000_0003));
		load_items.push_back(make_acc(17'd9, 32'h0000_0100, 32'h0123_4567, 32'h0000_0001,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_0000, 32'h0000_FFFF,
			32'h0, 32'h7FFF_FFFF));
		load_items.push_back(make_read(17'd9));
		// Contribution of exactly the most negative entry still sets the mark.
		load_items.push_back(make_acc(17'd11, 32'h0001_0000, 32'hFF80_0000, 32'h0100_0000,
			32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0, 32'h0, 32'h0));
		load_items.push_back(make_read(17'd11));
		wait_until_drained();

		for (int p = 0; p < 4; p++) begin
			write_components(2'(phase_terms[p]));
			send_idle_pct = phase_send_idle[p];
			recv_idle_pct = phase_recv_idle[p];
			repeat (phase_items[p]) load_items.push_back(random_item());
			if (p == 3)
				hold_armed <= 1'b1;
			wait_until_drained();
		end

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### load_vector_scatter_accumulate.f
src/lvsa_pkg.sv
src/lvsa_ctrl.sv
src/lvsa_dp.sv
src/load_vector_scatter_accumulate.sv
src/lvsa_chk.sv
tb/sv/tb_load_vector_scatter_accumulate.sv
